[src/mod_pattern_cell_decoder_macros.svh]
// Assertion macros shared by the decoder RTL.
`ifndef MOD_PATTERN_CELL_DECODER_MACROS_SVH
`define MOD_PATTERN_CELL_DECODER_MACROS_SVH

// Check an implication on every rising clock edge outside reset.
`define MPCD_ASSERT_IMPL(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Check a next-cycle implication on every rising clock edge outside reset.
`define MPCD_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

[src/mpcd_pkg.sv]
package mpcd_pkg;

   localparam int FULL_TABLE      = 84;
   localparam int TABLE_NOTES_DEF = 84;
   localparam int NOTE_W          = 7;
   localparam int PERIOD_W        = 12;
   localparam int INSTR_W         = 8;
   localparam int EFFECT_W        = 4;
   localparam int ARG_W           = 8;
   localparam int REQ_DATA_W      = 32;
   localparam int RSP_DATA_W      = 40;

   // Periods for seven octaves of twelve semitones, lowest octave first.
   localparam logic [PERIOD_W-1:0] NOTE_PERIODS [FULL_TABLE] = '{
      12'd1712, 12'd1616, 12'd1525, 12'd1440, 12'd1357, 12'd1281,
      12'd1209, 12'd1141, 12'd1077, 12'd1017, 12'd960,  12'd907,
      12'd856,  12'd808,  12'd762,  12'd720,  12'd678,  12'd640,
      12'd604,  12'd570,  12'd538,  12'd508,  12'd480,  12'd453,
      12'd428,  12'd404,  12'd381,  12'd360,  12'd339,  12'd320,
      12'd302,  12'd285,  12'd269,  12'd254,  12'd240,  12'd226,
      12'd214,  12'd202,  12'd190,  12'd180,  12'd170,  12'd160,
      12'd151,  12'd143,  12'd135,  12'd127,  12'd120,  12'd113,
      12'd107,  12'd101,  12'd95,   12'd90,   12'd85,   12'd80,
      12'd75,   12'd71,   12'd67,   12'd63,   12'd60,   12'd56,
      12'd53,   12'd50,   12'd47,   12'd45,   12'd42,   12'd40,
      12'd37,   12'd35,   12'd33,   12'd31,   12'd30,   12'd28,
      12'd27,   12'd25,   12'd24,   12'd22,   12'd21,   12'd20,
      12'd19,   12'd18,   12'd17,   12'd16,   12'd15,   12'd14
   };

   // What one cell hands to its neighbor.
   typedef struct packed {
      logic [PERIOD_W-1:0] period;
      logic [INSTR_W-1:0]  instrument;
      logic [EFFECT_W-1:0] effect;
      logic [ARG_W-1:0]    argument;
      logic [PERIOD_W-1:0] best_gap;
      logic [NOTE_W-1:0]   best_note;
   } stage_type;

endpackage

[src/mpcd_cell.sv]
module mpcd_cell #(
   parameter int INDEX = 0
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               advance,
   input  logic               in_valid,
   input  mpcd_pkg::stage_type in_stage,
   output logic               out_valid,
   output mpcd_pkg::stage_type out_stage
);

   localparam logic [mpcd_pkg::PERIOD_W-1:0] ENTRY = mpcd_pkg::NOTE_PERIODS[INDEX];
   localparam logic [mpcd_pkg::NOTE_W-1:0]   NOTE  = mpcd_pkg::NOTE_W'(INDEX + 1);

   logic                            valid_ff;
   mpcd_pkg::stage_type             stage_ff;
   mpcd_pkg::stage_type             stage_in;
   logic [mpcd_pkg::PERIOD_W-1:0]   gap;

   always_comb begin
      gap = (in_stage.period > ENTRY) ? (in_stage.period - ENTRY)
                                      : (ENTRY - in_stage.period);
      stage_in = in_stage;
      // The first entry always wins; later ones only on a strictly smaller gap.
      if ((INDEX == 0) || (gap < in_stage.best_gap)) begin
         stage_in.best_gap  = gap;
         stage_in.best_note = NOTE;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (advance) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         stage_ff <= stage_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_stage = stage_ff;

endmodule

[src/mod_pattern_cell_decoder.sv]
// Channel | Direction | Handshake            | Payload
// req     | in        | req_tvalid/req_tready | req_tdata: four cell bytes
// rsp     | out       | rsp_tvalid/rsp_tready | rsp_tdata: decoded cell fields
//
// Throughput: one word per cycle while the result port is not held by an untaken result.
// The chain holds one cell per period table entry; the last
// cell's registers drive the result port.
// Reset clears the valid bit of every cell; payload registers are not reset.
// A result that is not taken holds the whole chain; words already in flight
// keep their places and req_tready drops until the result leaves.
`include "mod_pattern_cell_decoder_macros.svh"

module mod_pattern_cell_decoder #(
   parameter int TABLE_NOTES = mpcd_pkg::TABLE_NOTES_DEF
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_tvalid,
   output logic                                req_tready,
   // [7:0] cell_byte0, [15:8] cell_byte1, [23:16] cell_byte2, [31:24] cell_byte3
   input  logic [mpcd_pkg::REQ_DATA_W-1:0]     req_tdata,
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   // [6:0] note_number, [18:7] period_value, [26:19] instrument_number,
   // [30:27] effect_code, [38:31] effect_argument, [39] zero
   output logic [mpcd_pkg::RSP_DATA_W-1:0]     rsp_tdata
);

   localparam logic [mpcd_pkg::NOTE_W-1:0] NOTE_MAX = mpcd_pkg::NOTE_W'(TABLE_NOTES);

   logic                      advance;
   logic [TABLE_NOTES:0]      valid_chain;
   mpcd_pkg::stage_type       stage_chain [TABLE_NOTES+1];
   mpcd_pkg::stage_type       head;
   mpcd_pkg::stage_type       tail;
   logic [mpcd_pkg::NOTE_W-1:0] note;

   // Move the whole chain unless a finished result is still waiting.
   assign advance    = !rsp_tvalid || rsp_tready;
   assign req_tready = advance;

   // Unpack the cell bytes; the search fields start empty, cell 0 fills them.
   always_comb begin
      head            = '0;
      head.period     = {req_tdata[3:0], req_tdata[15:8]};
      head.instrument = {req_tdata[7:4], req_tdata[23:20]};
      head.effect     = req_tdata[19:16];
      head.argument   = req_tdata[31:24];
   end

   assign valid_chain[0] = req_tvalid;
   assign stage_chain[0] = head;

   // One cell per table entry, each comparing against its own constant period.
   for (genvar i = 0; i < TABLE_NOTES; i++) begin : g_cell
      mpcd_cell #(
         .INDEX (i)
      ) u_cell (
         .clock     (clock),
         .reset     (reset),
         .advance   (advance),
         .in_valid  (valid_chain[i]),
         .in_stage  (stage_chain[i]),
         .out_valid (valid_chain[i+1]),
         .out_stage (stage_chain[i+1])
      );
   end

   assign tail = stage_chain[TABLE_NOTES];

   // A zero period means no note.
   assign note = (tail.period == '0) ? '0 : tail.best_note;

   assign rsp_tvalid = valid_chain[TABLE_NOTES];
   assign rsp_tdata  = {1'b0, tail.argument, tail.effect, tail.instrument,
                        tail.period, note};

   `MPCD_ASSERT_IMPL(a_zero_note, rsp_tvalid, (note == '0) == (tail.period == '0), "zero note")
   `MPCD_ASSERT_IMPL(a_note_range, rsp_tvalid, note <= NOTE_MAX, "note beyond table")
   `MPCD_ASSERT_NEXT(a_hold_chain, !advance, $stable(valid_chain[TABLE_NOTES:1]), "chain moved")

endmodule

[test/mod_pattern_cell_decoder_test.sv]
`timescale 1ns / 100ps

module mod_pattern_cell_decoder_test;

   localparam int RESET_CYCLES = 9;
   localparam int PIPE_DEPTH   = mpcd_pkg::TABLE_NOTES_DEF;
   // Cycles with no word moving on either side before the run is declared hung.
   localparam int QUIET_LIMIT  = 4000;
   localparam int CELLS_PER_PHASE = 410;

   // Period table, octave 0 first; searched front to back, strict compare,
   // so on equal distance the earlier (longer period, lower note) entry wins.
   localparam int NOTE_PERIOD_LUT [84] = '{
      1712, 1616, 1525, 1440, 1357, 1281, 1209, 1141, 1077, 1017,  960,  907,
       856,  808,  762,  720,  678,  640,  604,  570,  538,  508,  480,  453,
       428,  404,  381,  360,  339,  320,  302,  285,  269,  254,  240,  226,
       214,  202,  190,  180,  170,  160,  151,  143,  135,  127,  120,  113,
       107,  101,   95,   90,   85,   80,   75,   71,   67,   63,   60,   56,
        53,   50,   47,   45,   42,   40,   37,   35,   33,   31,   30,   28,
        27,   25,   24,   22,   21,   20,   19,   18,   17,   16,   15,   14
   };

   // Decoded cell as it leaves the block, one field per rsp_tdata slice.
   typedef struct packed {
      logic                          pad;
      logic [mpcd_pkg::ARG_W-1:0]    argument;
      logic [mpcd_pkg::EFFECT_W-1:0] effect;
      logic [mpcd_pkg::INSTR_W-1:0]  instrument;
      logic [mpcd_pkg::PERIOD_W-1:0] period;
      logic [mpcd_pkg::NOTE_W-1:0]   note;
   } cell_fields_type;

   logic                             clock      = 1'b0;
   logic                             reset      = 1'b1;
   logic                             req_tvalid = 1'b0;
   logic                             req_tready;
   logic [mpcd_pkg::REQ_DATA_W-1:0]  req_tdata  = '0;
   logic                             rsp_tvalid;
   logic                             rsp_tready = 1'b0;
   logic [mpcd_pkg::RSP_DATA_W-1:0]  rsp_tdata;

   int idle_pct  = 0;   // chance per cycle that the sender holds back
   int stall_pct = 0;   // chance per cycle that the receiver stalls
   int quiet_cycles = 0;

   // Work out the fields of one cell; flag when the nearest-note search hit a tie.
   function automatic cell_fields_type decode_cell(input logic [31:0] word, output bit tie);
      cell_fields_type f;
      int           per;
      int           gap;
      int           best_gap;
      begin
         tie          = 1'b0;
         f            = '0;
         f.period     = {word[3:0], word[15:8]};
         f.instrument = {word[7:4], word[23:20]};
         f.effect     = word[19:16];
         f.argument   = word[31:24];
         per          = f.period;
         best_gap     = 32'hFFFF;
         if (per != 0) begin
            for (int i = 0; i < 84; i++) begin
               gap = (per > NOTE_PERIOD_LUT[i]) ? per - NOTE_PERIOD_LUT[i]
                                                : NOTE_PERIOD_LUT[i] - per;
               if (gap < best_gap) begin
                  best_gap = gap;
                  f.note   = mpcd_pkg::NOTE_W'(i + 1);
               end else if (gap == best_gap) begin
                  tie = 1'b1;
               end
            end
         end
         return f;
      end
   endfunction

   class decode_scoreboard;
      cell_fields_type pending_cells[$];
      int fail_count = 0;
      int checked    = 0;
      int zero_count = 0;
      int tie_count  = 0;

      // Note a cell word taken by the block; queue its expected fields.
      function void note_cell(logic [31:0] word);
         bit tie;
         cell_fields_type f;
         f = decode_cell(word, tie);
         if (tie) tie_count++;
         if (f.period == 0) zero_count++;
         pending_cells.push_back(f);
      endfunction

      // Compare a result word against the oldest pending cell.
      function void check_word(logic [mpcd_pkg::RSP_DATA_W-1:0] word);
         cell_fields_type want;
         cell_fields_type got;
         got = word;
         if (pending_cells.size() == 0) begin
            $error("result word %h with no cell pending", word);
            fail_count++;
            return;
         end
         want = pending_cells.pop_front();
         checked++;
         if (got.note !== want.note) begin
            $error("note_number: expected %0d, got %0d", want.note, got.note);
            fail_count++;
         end
         if (got.period !== want.period) begin
            $error("period_value: expected %0d, got %0d", want.period, got.period);
            fail_count++;
         end
         if (got.instrument !== want.instrument) begin
            $error("instrument_number: expected %0d, got %0d",
                   want.instrument, got.instrument);
            fail_count++;
         end
         if (got.effect !== want.effect) begin
            $error("effect_code: expected %0d, got %0d", want.effect, got.effect);
            fail_count++;
         end
         if (got.argument !== want.argument) begin
            $error("effect_argument: expected %0d, got %0d", want.argument, got.argument);
            fail_count++;
         end
         if (got.pad !== want.pad) begin
            $error("pad bit: expected %0d, got %0d", want.pad, got.pad);
            fail_count++;
         end
      endfunction

      function int pending_count();
         return pending_cells.size();
      endfunction
   endclass

   decode_scoreboard board = new();

   mod_pattern_cell_decoder u_top (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // Receiver: stall at random according to the current phase.
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= ($urandom_range(99) >= stall_pct);
      end
   end

   // Monitor and watchdog: check each result word taken, and count cycles
   // in which no word moves on either side.
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_tvalid && rsp_tready) begin
            board.check_word(rsp_tdata);
         end
         if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
            quiet_cycles <= 0;
         end else begin
            quiet_cycles <= quiet_cycles + 1;
         end
         if (quiet_cycles >= QUIET_LIMIT) begin
            $display("watchdog: no word moved for %0d cycles, %0d cells pending",
                     quiet_cycles, board.pending_count());
            $display("[FAIL] regression broken");
            $finish;
         end
      end
   end

   // Offer one cell word, idling first as the phase says; hold it until taken.
   // Called just after a rising edge, so valid gets one assignment per step.
   task automatic send_cell(input logic [31:0] word);
      while ($urandom_range(99) < idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= word;
      do @(posedge clock); while (!req_tready);
      board.note_cell(word);
   endtask

   // Pack a period with random instrument nibbles, effect and argument.
   function automatic logic [31:0] pack_cell(input int per);
      logic [11:0] p;
      logic [7:0]  b0, b1, b2, b3;
      begin
         p  = per[11:0];
         b0 = {4'($urandom_range(15)), p[11:8]};
         b1 = p[7:0];
         b2 = 8'($urandom_range(255));
         b3 = 8'($urandom_range(255));
         return {b3, b2, b1, b0};
      end
   endfunction

   // Random period: mostly near table entries and midpoints between neighbors,
   // where the nearest-note search is decided; the rest zero, above the table
   // or anywhere in the 12-bit range.
   function automatic int random_period();
      int sel;
      int idx;
      begin
         sel = $urandom_range(99);
         idx = $urandom_range(83);
         if (sel < 35) begin
            return NOTE_PERIOD_LUT[idx] + int'($urandom_range(4)) - 2;
         end else if (sel < 55 && idx < 83) begin
            return (NOTE_PERIOD_LUT[idx] + NOTE_PERIOD_LUT[idx + 1]) / 2
                   + int'($urandom_range(2)) - 1;
         end else if (sel < 62) begin
            return 0;
         end else if (sel < 70) begin
            return 1713 + int'($urandom_range(2382));
         end
         return int'($urandom_range(4095));
      end
   endfunction

   initial begin
      // Directed periods: zero, bottom and top of the range, entries at both
      // ends of the table, just outside it, and exact ties between neighbors.
      int edge_periods [18] = '{0, 1, 13, 14, 15, 20, 23, 29, 832, 1664,
                                1712, 1713, 2048, 4095, 1000, 1481, 1482, 1483};
      int per;
      logic [31:0] word;
      int phase_idle  [4] = '{0, 51, 0, 25};
      int phase_stall [4] = '{0, 0, 51, 25};

      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed part: extremes first, then the edge periods with every
      // effect code and alternating nibble patterns.
      send_cell(32'h0000_0000);
      send_cell(32'hFFFF_FFFF);
      for (int i = 0; i < 18; i++) begin
         per  = edge_periods[i];
         word = {(i % 2) ? 8'hFF : 8'h00,
                 (i % 3 == 0) ? 4'hF : 4'h5, 4'(i),
                 8'(per),
                 (i % 2) ? 4'h0 : 4'hA, 4'(per >> 8)};
         send_cell(word);
      end

      // Random part in four handshake pressure phases.
      for (int ph = 0; ph < 4; ph++) begin
         idle_pct  = phase_idle[ph];
         stall_pct = phase_stall[ph];
         for (int n = 0; n < CELLS_PER_PHASE; n++) begin
            send_cell(pack_cell(random_period()));
         end
      end
      req_tvalid <= 1'b0;

      // Drain: wait for every pending cell, then let the pipe run empty
      // to catch any stray extra word.
      while (board.pending_count() != 0) @(posedge clock);
      repeat (PIPE_DEPTH + 16) @(posedge clock);

      $display("checked %0d decoded cells over four idle/stall phases",
               board.checked);
      $display("%0d cells with zero period, %0d resolved on a tie between notes",
               board.zero_count, board.tie_count);
      if (board.fail_count == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end

endmodule

[files.f]
+incdir+src
src/mpcd_pkg.sv
src/mpcd_cell.sv
src/mod_pattern_cell_decoder.sv
test/mod_pattern_cell_decoder_test.sv
